@@ rtl/core/rtte_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rtte_pkg
// Types and constants shared by the round-trip time estimator files.
// ----------------------------------------------------------------------------
package rtte_pkg;

  localparam int SEQ_W   = 32;
  localparam int STAMP_W = 48;
  localparam int RTT_W   = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_RTT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_LIMIT = 1'd1;

  localparam logic [RTT_W-1:0] INITIAL_RTT_RESET = 16'd300;
  localparam logic [CFG_W-1:0] NOISE_LIMIT_RESET = 16'd1000;

  // request codes
  localparam logic REQ_SEND = 1'b0;
  localparam logic REQ_ACK  = 1'b1;

  // floor(x/5) = (x * RECIP_5) >> RECIP_SHIFT, exact for x < 699050
  localparam int ACC_W       = RTT_W + 3;
  localparam int RECIP_SHIFT = 21;
  localparam logic [ACC_W-1:0] RECIP_5 = 19'd419431;
  localparam int PROD_W      = 2 * ACC_W;

  typedef struct packed {
    logic               req_type;
    logic [SEQ_W-1:0]   seq;
    logic [STAMP_W-1:0] now_msec;
  } req_t;

  typedef struct packed {
    logic [RTT_W-1:0] smoothed_rtt_msec;
    logic             matched;
    logic             sample_taken;
  } rsp_t;

  // one history entry
  typedef struct packed {
    logic               valid;
    logic [SEQ_W-1:0]   seq;
    logic [STAMP_W-1:0] stamp;
  } rec_t;

  // search token passed along the chain
  typedef struct packed {
    logic               tok;
    logic               found;
    logic [STAMP_W-1:0] stamp;
  } probe_t;

endpackage
`default_nettype wire

@@ rtl/core/rtte_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rtte_if
// Valid/ready channels for request and response words.
// ----------------------------------------------------------------------------
interface rtte_req_if;
  logic          valid;
  logic          ready;
  rtte_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rtte_rsp_if;
  logic          valid;
  logic          ready;
  rtte_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/rtte_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rtte_cell
// One history slot. Shifts its record to the older neighbor on a send and
// passes the search token on, claiming it on the first sequence match.
// ----------------------------------------------------------------------------
module rtte_cell (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           shift,
  input  wire rtte_pkg::rec_t           rec_in,
  output rtte_pkg::rec_t                rec_out,
  input  wire [rtte_pkg::SEQ_W-1:0]     qseq,
  input  wire rtte_pkg::probe_t         probe_in,
  output rtte_pkg::probe_t              probe_out
);

  rtte_pkg::rec_t   rec;
  rtte_pkg::probe_t probe;
  logic             hit;

  assign hit = rec.valid && (rec.seq == qseq) && probe_in.tok && !probe_in.found;

  always_ff @(posedge clk) begin
    if (rst) begin
      rec.valid <= 1'b0;
    end else if (shift) begin
      rec.valid <= rec_in.valid;
    end
    if (shift) begin
      rec.seq   <= rec_in.seq;
      rec.stamp <= rec_in.stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe.tok <= 1'b0;
    end else begin
      probe.tok <= probe_in.tok;
    end
    probe.found <= probe_in.found || hit;
    probe.stamp <= hit ? rec.stamp : probe_in.stamp;
  end

  assign rec_out   = rec;
  assign probe_out = probe;

endmodule
`default_nettype wire

@@ rtl/core/rtt_estimator_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rtt_estimator_unit
// Smoothed round-trip time estimator over a shifting send history.
// ----------------------------------------------------------------------------
// req carries send (record seq/time) and ack words; rsp returns one word per
// request: the estimate after it plus matched and sample_taken flags.
// The history is a row of HISTORY_DEPTH cells, newest at cell 0. A send
// shifts the row by one cell and its response is ready the next cycle.
// An ack launches a token down the row, one cell per cycle; the first cell
// holding an equal sequence number claims it. An ack goes through the walk
// through the cells, then the time check, the multiply by the reciprocal
// of 5, and the response load. One request is in flight at a time. Sends
// can follow back to back; after an ack the next request is taken only
// once that ack has finished and the unit is back in its idle state.
// Any request is taken only when the unit is idle and the response register
// is free or draining; an ack also waits at the end for that register. A
// stalled receiver holds the response word and, through that, further
// requests.
// Reset clears all history valid bits at once (no sweep), sets the
// estimate to 300 ms and the noise limit to 1000 ms. Writes to the initial
// estimate register have no effect; the estimate always resets to 300 ms.
// ----------------------------------------------------------------------------
module rtt_estimator_unit #(
  parameter int HISTORY_DEPTH = 128
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_we,
  input  wire [rtte_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [rtte_pkg::CFG_W-1:0]          cfg_wdata,
  rtte_req_if.sink                           req,
  rtte_rsp_if.source                         rsp
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_MUL    = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  logic [1:0]                      state;
  logic [rtte_pkg::CFG_W-1:0]      noise_limit;
  logic [rtte_pkg::RTT_W-1:0]      rtt;
  logic [rtte_pkg::RTT_W-1:0]      rtt_next;
  logic [rtte_pkg::SEQ_W-1:0]      qseq;
  logic [rtte_pkg::STAMP_W-1:0]    qnow;
  logic                            start;
  logic                            found;
  logic                            take;
  logic [rtte_pkg::RTT_W-1:0]      sample;
  logic [rtte_pkg::PROD_W-1:0]     prod;
  logic [rtte_pkg::ACC_W-1:0]      acc;
  logic [rtte_pkg::STAMP_W-1:0]    diff;
  logic                            take_next;
  logic                            out_free;
  logic                            accept;
  logic                            shift;
  rtte_pkg::rsp_t                  out_word;
  logic                            out_valid;

  rtte_pkg::rec_t   new_rec;
  rtte_pkg::rec_t   rec_q   [HISTORY_DEPTH];
  rtte_pkg::probe_t probe_in0;
  rtte_pkg::probe_t probe_q [HISTORY_DEPTH];
  rtte_pkg::probe_t last;

  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == ST_IDLE) && out_free;
  assign accept    = req.valid && req.ready;
  assign shift     = accept && (req.data.req_type == rtte_pkg::REQ_SEND);

  assign new_rec.valid = 1'b1;
  assign new_rec.seq   = req.data.seq;
  assign new_rec.stamp = req.data.now_msec;

  assign probe_in0.tok   = start;
  assign probe_in0.found = 1'b0;
  assign probe_in0.stamp = '0;

  genvar gi;
  generate
    for (gi = 0; gi < HISTORY_DEPTH; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        rtte_cell u_cell (
          .clk       (clk),
          .rst       (rst),
          .shift     (shift),
          .rec_in    (new_rec),
          .rec_out   (rec_q[gi]),
          .qseq      (qseq),
          .probe_in  (probe_in0),
          .probe_out (probe_q[gi])
        );
      end else begin : g_body
        rtte_cell u_cell (
          .clk       (clk),
          .rst       (rst),
          .shift     (shift),
          .rec_in    (rec_q[gi-1]),
          .rec_out   (rec_q[gi]),
          .qseq      (qseq),
          .probe_in  (probe_q[gi-1]),
          .probe_out (probe_q[gi])
        );
      end
    end
  endgenerate

  assign last = probe_q[HISTORY_DEPTH-1];

  // time check on the token leaving the last cell
  assign diff      = qnow - last.stamp;
  assign take_next = last.found && (qnow > last.stamp) &&
                     (diff < {{(rtte_pkg::STAMP_W-rtte_pkg::CFG_W){1'b0}}, noise_limit});
  assign acc       = {1'b0, rtt, 2'b00} + {{(rtte_pkg::ACC_W-rtte_pkg::RTT_W){1'b0}}, sample};
  assign rtt_next  = take ? prod[rtte_pkg::RECIP_SHIFT +: rtte_pkg::RTT_W] : rtt;

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_limit <= rtte_pkg::NOISE_LIMIT_RESET;
    end else if (cfg_we && (cfg_index == rtte_pkg::REG_NOISE_LIMIT)) begin
      noise_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      start     <= 1'b0;
      rtt       <= rtte_pkg::INITIAL_RTT_RESET;
      out_valid <= 1'b0;
    end else begin
      start <= accept && (req.data.req_type == rtte_pkg::REQ_ACK);
      if (shift || ((state == ST_DONE) && out_free)) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && (req.data.req_type == rtte_pkg::REQ_ACK)) begin
            state <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (last.tok) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            rtt   <= rtt_next;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      qseq <= req.data.seq;
      qnow <= req.data.now_msec;
    end
    if ((state == ST_SEARCH) && last.tok) begin
      found  <= last.found;
      take   <= take_next;
      sample <= diff[rtte_pkg::RTT_W-1:0];
    end
    if (state == ST_MUL) begin
      prod <= acc * rtte_pkg::RECIP_5;
    end
    if (shift) begin
      out_word.smoothed_rtt_msec <= rtt;
      out_word.matched           <= 1'b0;
      out_word.sample_taken      <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      out_word.smoothed_rtt_msec <= rtt_next;
      out_word.matched           <= found;
      out_word.sample_taken      <= take;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_word;

  // the token only leaves the row during a search
  a_tok_in_search : assert property (@(posedge clk) disable iff (rst)
    last.tok |-> (state == ST_SEARCH))
    else $error("search token left the row outside a search");

  // history moves only on an accepted send
  a_shift_idle : assert property (@(posedge clk) disable iff (rst)
    shift |-> (state == ST_IDLE))
    else $error("history shifted while busy");

  // estimate changes only when an ack completes
  a_rtt_stable : assert property (@(posedge clk) disable iff (rst)
    (state != ST_DONE) |=> $stable(rtt))
    else $error("estimate changed outside ack completion");

  // a taken sample implies a match
  a_take_match : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_word.sample_taken || out_word.matched))
    else $error("sample taken without a match");

  // a finished ack never overwrites a waiting response
  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DONE) && out_valid && !rsp.ready) |=> (state == ST_DONE))
    else $error("response overwritten while stalled");

endmodule
`default_nettype wire

@@ test/rtt_estimator_unit_test.sv @@
// ----------------------------------------------------------------------------
// rtt_estimator_unit_test
// Self-checking bench for the round-trip time estimator. Send and ack words
// are fed through a randomly idling driver; every response word is compared
// against a local history/estimate tracker. Runs a directed set first, then
// random traffic under several noise-limit settings.
// ----------------------------------------------------------------------------
module rtt_estimator_unit_test;

  localparam int DEPTH = 128;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [rtte_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rtte_pkg::CFG_W-1:0] cfg_wdata;

  rtte_req_if req_ch ();
  rtte_rsp_if rsp_ch ();

  rtt_estimator_unit #(.HISTORY_DEPTH(DEPTH)) uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always #6 clk = ~clk;

  // tracker state
  logic [rtte_pkg::SEQ_W-1:0]   hist_seq   [DEPTH];
  logic [rtte_pkg::STAMP_W-1:0] hist_stamp [DEPTH];
  logic                         hist_valid [DEPTH];
  int                           hist_head;
  logic [rtte_pkg::RTT_W-1:0]   rtt_estimate;
  logic [rtte_pkg::CFG_W-1:0]   noise_limit;

  rtte_pkg::req_t pending_words[$];
  rtte_pkg::rsp_t expected_words[$];
  int   words_sent;
  int   words_seen;
  int   fail_count;

  function automatic rtte_pkg::rsp_t rtt_response_for(input rtte_pkg::req_t w);
    rtte_pkg::rsp_t o;
    int idx;
    longint unsigned sample;
    longint unsigned acc;
    o.matched = 1'b0;
    o.sample_taken = 1'b0;
    if (w.req_type == rtte_pkg::REQ_SEND) begin
      hist_seq[hist_head] = w.seq;
      hist_stamp[hist_head] = w.now_msec;
      hist_valid[hist_head] = 1'b1;
      hist_head = (hist_head == DEPTH - 1) ? 0 : hist_head + 1;
    end else begin
      idx = hist_head;
      for (int n = 0; n < DEPTH; n++) begin
        idx = (idx == 0) ? DEPTH - 1 : idx - 1;
        if (hist_valid[idx] && hist_seq[idx] == w.seq) begin
          o.matched = 1'b1;
          if (w.now_msec > hist_stamp[idx]) begin
            sample = longint'(w.now_msec - hist_stamp[idx]);
            if (sample < longint'(noise_limit)) begin
              acc = 4 * longint'(rtt_estimate) + sample;
              rtt_estimate = rtte_pkg::RTT_W'(acc / 5);
              o.sample_taken = 1'b1;
            end
          end
          break;
        end
      end
    end
    o.smoothed_rtt_msec = rtt_estimate;
    return o;
  endfunction

  function automatic rtte_pkg::req_t word(input logic t,
                                          input logic [rtte_pkg::SEQ_W-1:0] s,
                                          input logic [rtte_pkg::STAMP_W-1:0] n);
    rtte_pkg::req_t w;
    w.req_type = t;
    w.seq = s;
    w.now_msec = n;
    return w;
  endfunction

  // initial estimate writes have no effect in the unit, so the tracker ignores them
  task automatic write_reg(input logic [rtte_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rtte_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == rtte_pkg::REG_NOISE_LIMIT) noise_limit = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_words.size() != 0 || expected_words.size() != 0) @(posedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_words.push_back(rtt_response_for(req_ch.data));
        void'(pending_words.pop_front());
        words_sent++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_words.size() > 0 &&
            ((words_sent >= 200 && words_sent < 260) || $urandom_range(0, 99) >= 27)) begin
          req_ch.valid <= 1'b1;
          req_ch.data <= pending_words[0];
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor
  int hold_left;
  bit long_hold_done;
  always @(posedge clk) begin
    rtte_pkg::rsp_t exp_w;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        words_seen++;
        if (expected_words.size() == 0) begin
          $error("unexpected response word %p", rsp_ch.data);
          fail_count++;
        end else begin
          exp_w = expected_words.pop_front();
          if (rsp_ch.data.smoothed_rtt_msec !== exp_w.smoothed_rtt_msec) begin
            $error("smoothed_rtt_msec: expected %0d, got %0d",
                   exp_w.smoothed_rtt_msec, rsp_ch.data.smoothed_rtt_msec);
            fail_count++;
          end
          if (rsp_ch.data.matched !== exp_w.matched) begin
            $error("matched: expected %0d, got %0d", exp_w.matched, rsp_ch.data.matched);
            fail_count++;
          end
          if (rsp_ch.data.sample_taken !== exp_w.sample_taken) begin
            $error("sample_taken: expected %0d, got %0d",
                   exp_w.sample_taken, rsp_ch.data.sample_taken);
            fail_count++;
          end
        end
      end
      // one long hold-off so the unit backs up into the request side
      if (words_seen == 60 && !long_hold_done) begin
        long_hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (words_seen >= 200 && words_seen < 260) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= 27);
      end
    end
  end

  initial begin
    #(12 * 1000000);
    $display("status: fail");
    $finish;
  end

  initial begin
    int r;
    int k;
    logic t;
    logic [rtte_pkg::SEQ_W-1:0] s;
    logic [rtte_pkg::STAMP_W-1:0] n;
    logic [rtte_pkg::STAMP_W-1:0] clock_ms;
    logic [rtte_pkg::SEQ_W-1:0] sent_seqs[$];

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    words_sent = 0;
    words_seen = 0;
    fail_count = 0;
    hold_left = 0;
    long_hold_done = 1'b0;
    for (int j = 0; j < DEPTH; j++) hist_valid[j] = 1'b0;
    hist_head = 0;
    rtt_estimate = rtte_pkg::INITIAL_RTT_RESET;
    noise_limit = rtte_pkg::NOISE_LIMIT_RESET;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed words at reset defaults
    pending_words.push_back(word(rtte_pkg::REQ_ACK, 32'd0, 48'd0));           // empty history
    pending_words.push_back(word(rtte_pkg::REQ_SEND, 32'd0, 48'd0));
    pending_words.push_back(word(rtte_pkg::REQ_ACK, 32'd0, 48'd0));           // same time
    pending_words.push_back(word(rtte_pkg::REQ_ACK, 32'd0, 48'd1));           // sample of 1
    pending_words.push_back(word(rtte_pkg::REQ_SEND, 32'hFFFF_FFFF,
                                 48'hFFFF_FFFF_FFFF - 48'd999));
    pending_words.push_back(word(rtte_pkg::REQ_ACK, 32'hFFFF_FFFF,
                                 48'hFFFF_FFFF_FFFF));                         // just under limit
    pending_words.push_back(word(rtte_pkg::REQ_ACK, 32'hFFFF_FFFF, 48'd0));   // earlier than send
    pending_words.push_back(word(rtte_pkg::REQ_SEND, 32'hA5A5_5A5A, 48'd5000));
    pending_words.push_back(word(rtte_pkg::REQ_ACK, 32'hA5A5_5A5A, 48'd6000)); // exactly at limit
    pending_words.push_back(word(rtte_pkg::REQ_ACK, 32'hA5A5_5A5A, 48'd4000));
    pending_words.push_back(word(rtte_pkg::REQ_SEND, 32'd7, 48'd10000));
    pending_words.push_back(word(rtte_pkg::REQ_SEND, 32'd7, 48'd10500));
    pending_words.push_back(word(rtte_pkg::REQ_ACK, 32'd7, 48'd10600));       // newest duplicate
    pending_words.push_back(word(rtte_pkg::REQ_ACK, 32'd12345, 48'h5555_5555_5555)); // no match
    pending_words.push_back(word(rtte_pkg::REQ_SEND, 32'h5555_5555, 48'hAAAA_AAAA_AAAA));
    pending_words.push_back(word(rtte_pkg::REQ_ACK, 32'h5555_5555,
                                 48'hAAAA_AAAA_AAAA + 48'd60));
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      repeat (4) @(posedge clk);
      case (ph)
        0: begin
          write_reg(rtte_pkg::REG_NOISE_LIMIT, 16'hFFFF);
          write_reg(rtte_pkg::REG_INITIAL_RTT, 16'd0);
        end
        1: write_reg(rtte_pkg::REG_NOISE_LIMIT, 16'd1);
        2: begin
          write_reg(rtte_pkg::REG_NOISE_LIMIT, 16'd0);
          write_reg(rtte_pkg::REG_INITIAL_RTT, 16'hFFFF);
        end
        3: begin
          write_reg(rtte_pkg::REG_NOISE_LIMIT, rtte_pkg::CFG_W'($urandom_range(200, 3000)));
          write_reg(rtte_pkg::REG_INITIAL_RTT, rtte_pkg::CFG_W'($urandom));
        end
        default: write_reg(rtte_pkg::REG_NOISE_LIMIT, rtte_pkg::NOISE_LIMIT_RESET);
      endcase

      clock_ms = {16'($urandom_range(0, 16'hFFFE)), 32'($urandom)};
      for (int i = 0; i < 80; i++) begin
        // sender waits out everything in flight once mid-phase
        if (ph == 0 && i == 40) drain();
        clock_ms += rtte_pkg::STAMP_W'($urandom_range(0, 40));
        r = int'($urandom_range(0, 99));
        if (r < 45 || sent_seqs.size() == 0) begin
          s = ($urandom_range(0, 3) == 0) ? rtte_pkg::SEQ_W'($urandom_range(0, 15)) :
                                            rtte_pkg::SEQ_W'($urandom);
          pending_words.push_back(word(rtte_pkg::REQ_SEND, s, clock_ms));
          sent_seqs.push_back(s);
          if (sent_seqs.size() > 200) void'(sent_seqs.pop_front());
        end else if (r < 85) begin
          // ack a recent send, sometimes one already pushed out of the history
          k = int'($urandom_range(0, (sent_seqs.size() > 150) ? 150 : sent_seqs.size() - 1));
          s = sent_seqs[sent_seqs.size() - 1 - k];
          n = ($urandom_range(0, 7) == 0) ?
              clock_ms - rtte_pkg::STAMP_W'($urandom_range(0, 200)) : clock_ms;
          pending_words.push_back(word(rtte_pkg::REQ_ACK, s, n));
        end else begin
          t = 1'($urandom_range(0, 1));
          n = {16'($urandom_range(0, 65535)), 32'($urandom)};
          pending_words.push_back(word(t, rtte_pkg::SEQ_W'($urandom), n));
        end
      end
      drain();
    end

    repeat (DEPTH + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
